// ----- src/ffsa_pkg.sv -----
package ffsa_pkg;

    // Default sizes of the managed heap
    localparam int HEAP_BYTES_DEF   = 16384;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_SEGMENTS_DEF = 64;

    // Request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Response codes
    localparam logic [1:0] ST_ALLOC    = 2'd0;
    localparam logic [1:0] ST_RELEASED = 2'd1;
    localparam logic [1:0] ST_NOMEM    = 2'd2;
    localparam logic [1:0] ST_BADADDR  = 2'd3;

    // Command broadcast to every cell of the segment table
    typedef enum logic [2:0] {
        OP_NOP,
        OP_TAKE,
        OP_SPLIT,
        OP_MARK,
        OP_MERGE
    } cell_op_t;

endpackage

// ----- src/ffsa_cell.sv -----
module ffsa_cell #(
    parameter int CELL_IDX     = 0,
    parameter int HEAP_BYTES   = ffsa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
    parameter int IDX_W        = 6,
    parameter int ADDR_W       = $clog2(HEAP_BYTES),
    parameter int SIZE_W       = ADDR_W + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // broadcast command
    input  ffsa_pkg::cell_op_t   op,
    input  logic [IDX_W-1:0]     op_idx,
    input  logic [SIZE_W-1:0]    req_size,
    input  logic [ADDR_W-1:0]    req_addr,
    // left neighbor entry
    input  logic                 left_valid,
    input  logic                 left_free,
    input  logic [ADDR_W-1:0]    left_start,
    input  logic [SIZE_W-1:0]    left_size,
    // right neighbor entry
    input  logic                 right_valid,
    input  logic                 right_free,
    input  logic [ADDR_W-1:0]    right_start,
    input  logic [SIZE_W-1:0]    right_size,
    // own entry
    output logic                 seg_valid,
    output logic                 seg_free,
    output logic [ADDR_W-1:0]    seg_start,
    output logic [SIZE_W-1:0]    seg_size,
    // registered search flags
    output logic                 fit_flag,
    output logic                 exact_flag,
    output logic                 big_flag,
    output logic                 match_flag
);

    localparam logic [IDX_W:0]  MY_IDX = (IDX_W+1)'(CELL_IDX);
    localparam logic [SIZE_W:0] HDR    = (SIZE_W+1)'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

    logic              valid_reg, valid_next;
    logic              free_reg, free_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              fit_reg, exact_reg, big_reg, match_reg;

    logic [IDX_W:0]    idx_ext;
    logic [SIZE_W:0]   split_start;
    logic [SIZE_W:0]   split_size;
    logic [SIZE_W:0]   merge_size;
    logic [SIZE_W:0]   pay_addr;

    assign idx_ext     = {1'b0, op_idx};
    assign split_start = {2'b00, left_start} + HDR + {1'b0, req_size};
    assign split_size  = {1'b0, left_size} - {1'b0, req_size} - HDR;
    assign merge_size  = {1'b0, size_reg} + HDR + {1'b0, right_size};
    assign pay_addr    = {2'b00, start_reg} + HDR;

    // Update own entry from the command and the neighbors
    always_comb begin
        valid_next = valid_reg;
        free_next  = free_reg;
        start_next = start_reg;
        size_next  = size_reg;
        unique case (op)
            ffsa_pkg::OP_TAKE: begin
                if (MY_IDX == idx_ext) begin
                    free_next = 1'b0;
                end
            end
            ffsa_pkg::OP_MARK: begin
                if (MY_IDX == idx_ext) begin
                    free_next = 1'b1;
                end
            end
            ffsa_pkg::OP_SPLIT: begin
                if (MY_IDX == idx_ext) begin
                    size_next = req_size;
                    free_next = 1'b0;
                end else if (MY_IDX == idx_ext + 1'b1) begin
                    valid_next = 1'b1;
                    free_next  = 1'b1;
                    start_next = split_start[ADDR_W-1:0];
                    size_next  = split_size[SIZE_W-1:0];
                end else if (MY_IDX > idx_ext + 1'b1) begin
                    valid_next = left_valid;
                    free_next  = left_free;
                    start_next = left_start;
                    size_next  = left_size;
                end
            end
            ffsa_pkg::OP_MERGE: begin
                if (MY_IDX == idx_ext) begin
                    size_next = merge_size[SIZE_W-1:0];
                end else if (MY_IDX > idx_ext) begin
                    valid_next = right_valid;
                    free_next  = right_free;
                    start_next = right_start;
                    size_next  = right_size;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= (CELL_IDX == 0);
            free_reg  <= (CELL_IDX == 0);
            start_reg <= '0;
            size_reg  <= INIT_SIZE;
        end else begin
            valid_reg <= valid_next;
            free_reg  <= free_next;
            start_reg <= start_next;
            size_reg  <= size_next;
        end
    end

    // Register the search flags against the held request
    always_ff @(posedge aclk) begin
        fit_reg   <= valid_reg && free_reg && (size_reg >= req_size);
        exact_reg <= (size_reg == req_size);
        big_reg   <= ({1'b0, size_reg} > ({1'b0, req_size} + HDR));
        match_reg <= valid_reg && (pay_addr == {2'b00, req_addr});
    end

    assign seg_valid  = valid_reg;
    assign seg_free   = free_reg;
    assign seg_start  = start_reg;
    assign seg_size   = size_reg;
    assign fit_flag   = fit_reg;
    assign exact_flag = exact_reg;
    assign big_flag   = big_reg;
    assign match_flag = match_reg;

endmodule

// ----- src/first_fit_segment_allocator_core.sv -----
// First-fit segment allocator over a byte heap kept as a row of segment cells.
// Slave channel: one request per handshake. tuser = kind (0 allocate, 1 release);
// tdata = request_size, then release_addr. Master channel: one response per
// request. tuser = status; tdata = payload_addr (0 unless status is allocated).
// Requests are handled one at a time; s_tready is high only while idle.
// A request passes through S_LOOK, S_PICK and S_APPLY to S_RESP, with a merge
// state for each free neighbor on a release (S_MRG_R, then S_MRG_L). The cells
// register their search flags against the held request, a priority pick follows,
// then the table is shifted one step per split or merge.
// A stalled master holds the response; no new request is taken until the
// response has been accepted. Reset (aresetn low, synchronous) leaves one free
// segment covering the whole heap behind one header, with no other valid cell.
module first_fit_segment_allocator_core #(
    parameter int HEAP_BYTES   = ffsa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_W       = $clog2(HEAP_BYTES),
    parameter int SIZE_W       = ADDR_W + 1,
    parameter int S_DATA_W     = ((SIZE_W + ADDR_W + 7) / 8) * 8,
    parameter int M_DATA_W     = ((ADDR_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // request_size, release_addr, zero fill
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // payload_addr, zero fill
    output logic [1:0]          m_tuser    // status
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
    localparam logic [SIZE_W:0]  HDR     = (SIZE_W+1)'(HEADER_BYTES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOOK  = 7'b0000010,
        S_PICK  = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_MRG_R = 7'b0010000,
        S_MRG_L = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic               kind_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    ffsa_pkg::cell_op_t act_reg, act_next;
    logic               mrg_r_reg, mrg_r_next;
    logic               mrg_l_reg, mrg_l_next;
    logic [1:0]         status_reg, status_next;
    logic [ADDR_W-1:0]  pay_reg;

    ffsa_pkg::cell_op_t op;
    logic [IDX_W-1:0]   op_idx;

    logic [MAX_SEGMENTS-1:0] valid_v, free_v, fit_v, exact_v, big_v, match_v;
    logic [ADDR_W-1:0]       start_a [MAX_SEGMENTS];
    logic [SIZE_W-1:0]       size_a  [MAX_SEGMENTS];

    logic [IDX_W-1:0] fit_idx, match_idx;
    logic             fit_any, match_any;
    logic [CNT_W-1:0] last_cnt;
    logic [IDX_W-1:0] cand;
    logic [SIZE_W:0]  pay_sum;

    // Row of segment cells
    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
        logic              lv, lf, rv, rf;
        logic [ADDR_W-1:0] ls, rs;
        logic [SIZE_W-1:0] lz, rz;
        if (k == 0) begin : g_left_edge
            assign lv = 1'b0;
            assign lf = 1'b0;
            assign ls = '0;
            assign lz = '0;
        end else begin : g_left
            assign lv = valid_v[k-1];
            assign lf = free_v[k-1];
            assign ls = start_a[k-1];
            assign lz = size_a[k-1];
        end
        if (k == MAX_SEGMENTS - 1) begin : g_right_edge
            assign rv = 1'b0;
            assign rf = 1'b0;
            assign rs = '0;
            assign rz = '0;
        end else begin : g_right
            assign rv = valid_v[k+1];
            assign rf = free_v[k+1];
            assign rs = start_a[k+1];
            assign rz = size_a[k+1];
        end
        ffsa_cell #(
            .CELL_IDX    (k),
            .HEAP_BYTES  (HEAP_BYTES),
            .HEADER_BYTES(HEADER_BYTES),
            .IDX_W       (IDX_W),
            .ADDR_W      (ADDR_W),
            .SIZE_W      (SIZE_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .op_idx     (op_idx),
            .req_size   (size_reg),
            .req_addr   (addr_reg),
            .left_valid (lv),
            .left_free  (lf),
            .left_start (ls),
            .left_size  (lz),
            .right_valid(rv),
            .right_free (rf),
            .right_start(rs),
            .right_size (rz),
            .seg_valid  (valid_v[k]),
            .seg_free   (free_v[k]),
            .seg_start  (start_a[k]),
            .seg_size   (size_a[k]),
            .fit_flag   (fit_v[k]),
            .exact_flag (exact_v[k]),
            .big_flag   (big_v[k]),
            .match_flag (match_v[k])
        );
    end

    // Find the first fitting cell before the last one, and the matching cell
    assign last_cnt = count_reg - 1'b1;
    always_comb begin
        fit_any   = 1'b0;
        fit_idx   = '0;
        match_any = 1'b0;
        match_idx = '0;
        for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
            if (fit_v[k] && (CNT_W'(k) < last_cnt)) begin
                fit_any = 1'b1;
                fit_idx = IDX_W'(k);
            end
            if (match_v[k]) begin
                match_any = 1'b1;
                match_idx = IDX_W'(k);
            end
        end
    end
    assign cand = fit_any ? fit_idx : last_cnt[IDX_W-1:0];

    // Sequence the request through search, update and merges
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        act_next    = act_reg;
        mrg_r_next  = mrg_r_reg;
        mrg_l_next  = mrg_l_reg;
        status_next = status_reg;
        op          = ffsa_pkg::OP_NOP;
        op_idx      = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next = S_PICK;
            end
            S_PICK: begin
                state_next = S_APPLY;
                mrg_r_next = 1'b0;
                mrg_l_next = 1'b0;
                act_next   = ffsa_pkg::OP_NOP;
                if (kind_reg == ffsa_pkg::KIND_ALLOC) begin
                    idx_next    = cand;
                    status_next = ffsa_pkg::ST_NOMEM;
                    if (free_v[cand]) begin
                        if (exact_v[cand]) begin
                            act_next    = ffsa_pkg::OP_TAKE;
                            status_next = ffsa_pkg::ST_ALLOC;
                        end else if (big_v[cand] && count_reg < MAX_CNT) begin
                            act_next    = ffsa_pkg::OP_SPLIT;
                            status_next = ffsa_pkg::ST_ALLOC;
                        end
                    end
                end else if (match_any) begin
                    idx_next    = match_idx;
                    act_next    = ffsa_pkg::OP_MARK;
                    status_next = ffsa_pkg::ST_RELEASED;
                    if (match_idx != IDX_W'(MAX_SEGMENTS - 1)) begin
                        mrg_r_next = valid_v[match_idx + 1'b1] && free_v[match_idx + 1'b1];
                    end
                    if (match_idx != '0) begin
                        mrg_l_next = free_v[match_idx - 1'b1];
                    end
                end else begin
                    status_next = ffsa_pkg::ST_BADADDR;
                end
            end
            S_APPLY: begin
                op = act_reg;
                if (act_reg == ffsa_pkg::OP_SPLIT) begin
                    count_next = count_reg + 1'b1;
                end
                priority if (mrg_r_reg) begin
                    state_next = S_MRG_R;
                end else if (mrg_l_reg) begin
                    state_next = S_MRG_L;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_MRG_R: begin
                op         = ffsa_pkg::OP_MERGE;
                count_next = count_reg - 1'b1;
                state_next = mrg_l_reg ? S_MRG_L : S_RESP;
            end
            S_MRG_L: begin
                op         = ffsa_pkg::OP_MERGE;
                op_idx     = idx_reg - 1'b1;
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign pay_sum = {2'b00, start_a[idx_reg]} + HDR;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= CNT_W'(1);
            act_reg    <= ffsa_pkg::OP_NOP;
            mrg_r_reg  <= 1'b0;
            mrg_l_reg  <= 1'b0;
            status_reg <= ffsa_pkg::ST_NOMEM;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            act_reg    <= act_next;
            mrg_r_reg  <= mrg_r_next;
            mrg_l_reg  <= mrg_l_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
        end
    end

    // Hold the request fields and capture the granted payload offset
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            kind_reg <= s_tuser;
            size_reg <= s_tdata[SIZE_W-1:0];
            addr_reg <= s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
        end
        if (state_reg == S_APPLY) begin
            pay_reg <= (status_reg == ffsa_pkg::ST_ALLOC) ? pay_sum[ADDR_W-1:0] : '0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);
    assign m_tuser  = status_reg;
    assign m_tdata  = M_DATA_W'(pay_reg);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= MAX_CNT))
        else $error("segment count out of range");

    a_first_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_v[0])
        else $error("first segment cell lost");

    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ffsa_pkg::ST_ALLOC) |-> (m_tdata == '0))
        else $error("nonzero address on failed or release response");

    a_split_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && act_reg == ffsa_pkg::OP_SPLIT)
            |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("split did not add a segment");
`endif

endmodule
